// ===== rtl/fenwick_prefix_sum_table_top_defines.svh =====
// Assertion macros for the prefix-sum table top level.
// Each macro expects signals named clock and reset in the scope where it is used.
`ifndef FENWICK_PREFIX_SUM_TABLE_TOP_DEFINES_SVH
`define FENWICK_PREFIX_SUM_TABLE_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FPS_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FPS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/fps_pkg.sv =====
// Shared constants, types and helper functions for the prefix-sum table.
// Has no dependencies; every other file but the defines header imports it.
`timescale 1ns / 1ps

package fps_pkg;

   localparam int TABLE_SIZE = 1024;
   localparam int NODE_WIDTH = 40;
   localparam int ADDR_W     = $clog2(TABLE_SIZE);
   localparam int POS_W      = 11;
   localparam int DELTA_W    = 32;
   localparam int TOTAL_W    = 40;
   localparam int WALK_W     = (ADDR_W + 2 > POS_W + 1) ? ADDR_W + 2 : POS_W + 1;

   localparam logic CMD_UPDATE = 1'b0;
   localparam logic CMD_QUERY  = 1'b1;

   typedef logic [NODE_WIDTH-1:0] node_type;
   typedef logic [WALK_W-1:0]     walk_type;
   typedef logic [ADDR_W-1:0]     addr_type;

   typedef struct packed {
      logic load;
      logic step;
      logic clear_en;
      logic rsp_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic pos_live;
      logic pend;
      logic clear_last;
      logic is_query;
   } dp_stat_type;

   function automatic node_type widen_delta(input logic signed [DELTA_W-1:0] d);
      logic signed [63:0] w;
      w = 64'(d);
      return w[NODE_WIDTH-1:0];
   endfunction

   function automatic logic [TOTAL_W-1:0] node_to_total(input node_type v);
      logic signed [63:0] w;
      w = 64'(signed'(v));
      return w[TOTAL_W-1:0];
   endfunction

endpackage

// ===== rtl/fps_if.sv =====
// Valid/ready channel interfaces for the request and response sides.
// Depends on fps_pkg for the payload widths.
`timescale 1ns / 1ps

interface fps_req_if import fps_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic                      cmd;
   logic [POS_W-1:0]          position;
   logic signed [DELTA_W-1:0] delta;

   modport source(output valid, output cmd, output position, output delta, input ready);
   modport sink(input valid, input cmd, input position, input delta, output ready);
endinterface

interface fps_rsp_if import fps_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [TOTAL_W-1:0] prefix_total;

   modport source(output valid, output prefix_total, input ready);
   modport sink(input valid, input prefix_total, output ready);
endinterface

// ===== rtl/fps_dpath.sv =====
// Datapath of the prefix-sum table: node memory, index walker and accumulator.
// Driven by fps_ctrl through the command struct; depends on fps_pkg.
`timescale 1ns / 1ps

module fps_dpath
   import fps_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  ctrl_cmd_type              cmd,
   input  logic                      req_cmd,
   input  logic [POS_W-1:0]          req_position,
   input  logic signed [DELTA_W-1:0] req_delta,
   output dp_stat_type               stat,
   output logic [TOTAL_W-1:0]        rsp_prefix_total
);

   node_type             node_mem_ff [TABLE_SIZE];
   node_type             rd_data_ff;
   walk_type             pos_ff, pos_in;
   node_type             delta_ff;
   logic                 query_ff;
   node_type             acc_ff, acc_in;
   logic                 pend_ff;
   addr_type             pend_addr_ff;
   addr_type             clr_addr_ff, clr_addr_in;
   logic [TOTAL_W-1:0]   total_ff;

   walk_type             pos_ext, pos_start, pos_dec, low_bit, pos_next;
   addr_type             node_addr, wr_addr;
   node_type             wr_data;
   logic                 wr_en;

   always_comb begin
      pos_ext = WALK_W'(req_position);
      if (req_cmd == CMD_QUERY && pos_ext > WALK_W'(TABLE_SIZE)) begin
         pos_start = WALK_W'(TABLE_SIZE);
      end else begin
         pos_start = pos_ext;
      end
      pos_dec   = pos_ff - walk_type'(1);
      node_addr = pos_dec[ADDR_W-1:0];
      low_bit   = pos_ff & (~pos_ff + walk_type'(1));
      pos_next  = query_ff ? (pos_ff & pos_dec) : (pos_ff + low_bit);
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = pend_addr_ff;
      wr_data = rd_data_ff + delta_ff;
      if (cmd.clear_en) begin
         wr_en   = 1'b1;
         wr_addr = clr_addr_ff;
         wr_data = '0;
      end else if (pend_ff && !query_ff) begin
         wr_en = 1'b1;
      end
   end

   always_comb begin
      pos_in = pos_ff;
      if (cmd.load) begin
         pos_in = pos_start;
      end else if (cmd.step) begin
         pos_in = pos_next;
      end
      acc_in = acc_ff;
      if (cmd.load) begin
         acc_in = '0;
      end else if (pend_ff && query_ff) begin
         acc_in = acc_ff + rd_data_ff;
      end
      clr_addr_in = cmd.clear_en ? clr_addr_ff + addr_type'(1) : clr_addr_ff;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         node_mem_ff[wr_addr] <= wr_data;
      end
      if (cmd.step) begin
         rd_data_ff <= node_mem_ff[node_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff     <= 1'b0;
         clr_addr_ff <= '0;
      end else begin
         pend_ff     <= cmd.step;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      acc_ff <= acc_in;
      if (cmd.load) begin
         delta_ff <= widen_delta(req_delta);
         query_ff <= req_cmd;
      end
      if (cmd.step) begin
         pend_addr_ff <= node_addr;
      end
      if (cmd.rsp_load) begin
         total_ff <= node_to_total(acc_ff);
      end
   end

   assign stat.pos_live   = (pos_ff != '0) && (pos_ff <= WALK_W'(TABLE_SIZE));
   assign stat.pend       = pend_ff;
   assign stat.clear_last = (clr_addr_ff == ADDR_W'(TABLE_SIZE - 1));
   assign stat.is_query   = query_ff;

   assign rsp_prefix_total = total_ff;

endmodule

// ===== rtl/fps_ctrl.sv =====
// Controller of the prefix-sum table: clearing sweep, item transfer and walk sequencing.
// Talks to fps_dpath only through the command and status structs of fps_pkg.
`timescale 1ns / 1ps

module fps_ctrl
   import fps_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  dp_stat_type  stat,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic         rsp_ready,
   output logic         rsp_valid,
   output ctrl_cmd_type cmd
);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_WALK  = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free, walk_done;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign walk_done = !stat.pos_live && !stat.pend;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_en = 1'b1;
            if (stat.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            cmd.step = stat.pos_live;
            if (walk_done) begin
               if (!stat.is_query) begin
                  state_in = ST_IDLE;
               end else if (out_free) begin
                  cmd.rsp_load = 1'b1;
                  state_in     = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/fenwick_prefix_sum_table_top.sv =====
// Binary indexed prefix-sum table: point updates and prefix-sum queries over a node memory.
// The request channel (req_if) carries cmd, position and delta; a transfer takes one item.
// Updates produce nothing; a query returns prefix_total on the response channel (rsp_if).
// After reset the block clears its node memory, one entry a cycle, across all TABLE_SIZE
// (1024) entries; req_if.ready stays low until that sweep ends.
// An item walks one tree node per cycle through the single node memory, with a
// read-modify-write pipeline for updates; req_if.ready stays low from an item's transfer
// until its walk ends and, for a query, its result is loaded, so an item that touches no
// node, such as a query of position zero, still passes through the walk state.
// A query result appears in the response register the cycle after its walk ends, if that register is free.
// The response register decouples the sides: new requests are taken while a result waits.
// If the receiver stalls and a second query finishes, that query holds until the
// register frees, and requests stay blocked meanwhile.
// Depends on fps_pkg, fps_if, fps_ctrl, fps_dpath and the defines header.
`timescale 1ns / 1ps
`include "fenwick_prefix_sum_table_top_defines.svh"

module fenwick_prefix_sum_table_top
   import fps_pkg::*;
(
   input logic     clock,
   input logic     reset,
   fps_req_if.sink req_if,
   fps_rsp_if.source rsp_if
);

   ctrl_cmd_type ctrl_cmd;
   dp_stat_type  dp_stat;

   fps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .stat      (dp_stat),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_ready (rsp_if.ready),
      .rsp_valid (rsp_if.valid),
      .cmd       (ctrl_cmd)
   );

   fps_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (ctrl_cmd),
      .req_cmd          (req_if.cmd),
      .req_position     (req_if.position),
      .req_delta        (req_if.delta),
      .stat             (dp_stat),
      .rsp_prefix_total (rsp_if.prefix_total)
   );

   `FPS_ASSERT_SAME(a_no_transfer_in_clear, ctrl_cmd.clear_en, !req_if.ready, "ready in clear")
   `FPS_ASSERT_SAME(a_step_needs_live_pos, ctrl_cmd.step, dp_stat.pos_live, "read past walk")
   `FPS_ASSERT_NEXT(a_transfer_starts_clean, req_if.valid && req_if.ready, !dp_stat.pend, "stale")
   `FPS_ASSERT_SAME(a_rsp_no_overwrite, ctrl_cmd.rsp_load && rsp_if.valid, rsp_if.ready, "lost")

endmodule
